// File: src/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W = 3;
	localparam int OSS_W = 2;

	localparam logic [31:0] TEMP_OFFSET = 32'd4000;
	localparam logic [31:0] B4_BIAS = 32'd32768;
	localparam logic [31:0] B7_SCALE = 32'd50000;
	localparam logic [31:0] P_SQ_COEF = 32'd3038;
	localparam logic [31:0] P_LIN_COEF = 32'd7357;
	localparam logic [31:0] P_OFFSET = 32'd3791;

	typedef enum logic [IDX_W-1:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2 = 3'd3,
		REG_MC_MD = 3'd4,
		REG_OSS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
	} in_t;

	typedef struct packed {
		logic signed [15:0] temp_decicelsius;
		logic signed [31:0] press_pascal;
		logic div_error;
	} out_t;

	// side data carried through the temperature divider
	typedef struct packed {
		logic [31:0] x1;
		logic neg;
		logic err;
		logic [23:0] up;
	} tside_t;

	// side data carried through the pressure divider
	typedef struct packed {
		logic [15:0] temp;
		logic err;
		logic bz;
		logic split;
	} pside_t;

endpackage
`default_nettype wire

// File: src/bpc_div.sv
`default_nettype none
module bpc_div
	import bpc_pkg::*;
#(
	parameter int W = DATA_W,
	parameter int SIDE_W = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_vld,
	input wire logic [W-1:0] num,
	input wire logic [W-1:0] den,
	input wire logic [SIDE_W-1:0] side,
	output logic out_vld,
	output logic [W-1:0] quo,
	output logic [SIDE_W-1:0] side_out
);

	// one quotient bit per stage, restoring
	logic [W-1:0] num_s [W+1];
	logic [W-1:0] den_s [W+1];
	logic [W-1:0] rem_s [W+1];
	logic [W-1:0] quo_s [W+1];
	logic [SIDE_W-1:0] side_s [W+1];
	logic vld_s [W+1];

	always_comb begin
		num_s[0] = num;
		den_s[0] = den;
		rem_s[0] = '0;
		quo_s[0] = '0;
		side_s[0] = side;
		vld_s[0] = in_vld;
	end

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W:0] trial;
		logic ge;
		logic [W:0] diff;

		always_comb begin
			trial = {rem_s[k], num_s[k][W-1-k]};
			ge = trial >= {1'b0, den_s[k]};
			diff = trial - {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s[k+1] <= num_s[k];
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
				quo_s[k+1] <= quo_s[k] | (W'(ge) << (W-1-k));
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld = vld_s[W];
	assign quo = quo_s[W];
	assign side_out = side_s[W];

endmodule
`default_nettype wire

// File: src/baro_pressure_temp_compensation_unit.sv
`default_nettype none
// pressure / temperature compensation pipeline: every cycle it can take one item
// (raw temperature word plus raw 24-bit pressure reading) and returns one item
// with temperature in tenths of a degree, pressure in pascal and a flag for a
// zero divisor. its forward path holds 12 arithmetic stages
// (stages 1 to 11 plus the output register) and two 32-stage bit-per-stage
// dividers (one for the temperature correction, one for the pressure quotient).
// throughput is one item per cycle; the whole pipe advances whenever the output
// register is empty or being taken, so a stall on the output freezes every
// stage in place.
// calibration and oversampling registers are written over the config channel
// (always ready) and must only change while no item is in flight.
module baro_pressure_temp_compensation_unit
	import bpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [IDX_W-1:0] cfg_index,
	input wire logic [DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
	logic [OSS_W-1:0] oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q <= '0;
			mc_md_q <= '0;
			oss_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_AC1_AC2: ac1_ac2_q <= cfg_data;
				REG_AC3_AC4: ac3_ac4_q <= cfg_data;
				REG_AC5_AC6: ac5_ac6_q <= cfg_data;
				REG_B1_B2: b1_b2_q <= cfg_data;
				REG_MC_MD: mc_md_q <= cfg_data;
				REG_OSS: oss_q <= cfg_data[OSS_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficients, sign or zero extended to 32 bits
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0] ac4, ac5, ac6;

	always_comb begin
		ac1 = 32'(signed'(ac1_ac2_q[31:16]));
		ac2 = 32'(signed'(ac1_ac2_q[15:0]));
		ac3 = 32'(signed'(ac3_ac4_q[31:16]));
		ac4 = {16'd0, ac3_ac4_q[15:0]};
		ac5 = {16'd0, ac5_ac6_q[31:16]};
		ac6 = {16'd0, ac5_ac6_q[15:0]};
		b1 = 32'(signed'(b1_b2_q[31:16]));
		b2 = 32'(signed'(b1_b2_q[15:0]));
		mc = 32'(signed'(mc_md_q[31:16]));
		md = 32'(signed'(mc_md_q[15:0]));
	end

	// whole pipe moves together when the output can accept
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: align pressure, subtract ac6
	logic vld_s1;
	logic [31:0] d_s1;
	logic [23:0] up_s1;

	// stage 2: first temperature product
	logic vld_s2;
	logic signed [31:0] x1_s2;
	logic [23:0] up_s2;
	logic signed [31:0] prod_t;

	always_comb prod_t = signed'(d_s1 * ac5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= {16'd0, in_data.raw_temp} - ac6;
			up_s1 <= in_data.raw_press >> (4'd8 - {2'd0, oss_q});
			x1_s2 <= prod_t >>> 15;
			up_s2 <= up_s1;
		end
	end

	// temperature divider: (mc << 11) / (x1 + md), signs handled outside
	logic [31:0] tnum, tden, tden_mag, tnum_mag;
	tside_t tside_in, tside_out;
	logic tdv_vld;
	logic [31:0] tquo;

	always_comb begin
		tnum = mc << 11;
		tden = x1_s2 + md;
		tnum_mag = tnum[31] ? (32'd0 - tnum) : tnum;
		tden_mag = tden[31] ? (32'd0 - tden) : tden;
		tside_in.x1 = x1_s2;
		tside_in.neg = tnum[31] ^ tden[31];
		tside_in.err = (tden == 32'd0);
		tside_in.up = up_s2;
	end

	bpc_div #(
		.W(DATA_W),
		.SIDE_W($bits(tside_t))
	) u_tdiv (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_vld(vld_s2),
		.num(tnum_mag),
		.den(tden_mag),
		.side(tside_in),
		.out_vld(tdv_vld),
		.quo(tquo),
		.side_out(tside_out)
	);

	// stage 3: b5, b6
	logic vld_s3;
	logic [31:0] b5_s3, b6_s3;
	logic [23:0] up_s3;
	logic err_s3;
	logic [31:0] x2_t;

	always_comb begin
		if (tside_out.err) begin
			x2_t = '0;
		end else begin
			x2_t = tside_out.neg ? (32'd0 - tquo) : tquo;
		end
	end

	// stage 4: b6 products, temperature output
	logic vld_s4;
	logic [31:0] b6sq_raw_s4, ac2b6_s4, ac3b6_s4;
	logic [15:0] temp_s4;
	logic [23:0] up_s4;
	logic err_s4;
	logic signed [31:0] b5p8;

	always_comb b5p8 = signed'(b5_s3 + 32'd8);

	// stage 5: b6sq times b1 / b2
	logic vld_s5;
	logic [31:0] b2sq_s5, b1sq_s5, ac2b6_s5, ac3b6_s5;
	logic [15:0] temp_s5;
	logic [23:0] up_s5;
	logic err_s5;
	logic signed [31:0] b6sq;

	always_comb b6sq = signed'(b6sq_raw_s4) >>> 12;

	// stage 6: b3 and the b4 bracket
	logic vld_s6;
	logic [31:0] b3_s6, x3b_s6;
	logic [15:0] temp_s6;
	logic [23:0] up_s6;
	logic err_s6;
	logic signed [31:0] px1, px2, px3, pb3a, qx1, qx2, qx3;

	always_comb begin
		px1 = signed'(b2sq_s5) >>> 11;
		px2 = signed'(ac2b6_s5) >>> 11;
		px3 = px1 + px2;
		pb3a = signed'(((ac1 * 32'sd4 + px3) << oss_q) + 32'sd2);
		qx1 = signed'(ac3b6_s5) >>> 13;
		qx2 = signed'(b1sq_s5) >>> 16;
		qx3 = signed'(qx1 + qx2 + 32'sd2) >>> 2;
	end

	// stage 7: b4 and up - b3
	logic vld_s7;
	logic [31:0] b4_s7, t_s7;
	logic [15:0] temp_s7;
	logic err_s7;
	logic [31:0] b4_prod;

	always_comb b4_prod = ac4 * (x3b_s6 + B4_BIAS);

	// stage 8: b7
	logic vld_s8;
	logic [31:0] b7_s8, b4_s8;
	logic [15:0] temp_s8;
	logic err_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= tdv_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b5_s3 <= tside_out.x1 + x2_t;
			b6_s3 <= tside_out.x1 + x2_t - TEMP_OFFSET;
			up_s3 <= tside_out.up;
			err_s3 <= tside_out.err;

			b6sq_raw_s4 <= b6_s3 * b6_s3;
			ac2b6_s4 <= ac2 * b6_s3;
			ac3b6_s4 <= ac3 * b6_s3;
			temp_s4 <= 16'(b5p8 >>> 4);
			up_s4 <= up_s3;
			err_s4 <= err_s3;

			b2sq_s5 <= b2 * b6sq;
			b1sq_s5 <= b1 * b6sq;
			ac2b6_s5 <= ac2b6_s4;
			ac3b6_s5 <= ac3b6_s4;
			temp_s5 <= temp_s4;
			up_s5 <= up_s4;
			err_s5 <= err_s4;

			b3_s6 <= pb3a >>> 2;
			x3b_s6 <= qx3;
			temp_s6 <= temp_s5;
			up_s6 <= up_s5;
			err_s6 <= err_s5;

			b4_s7 <= b4_prod >> 15;
			t_s7 <= {8'd0, up_s6} - b3_s6;
			temp_s7 <= temp_s6;
			err_s7 <= err_s6;

			b7_s8 <= t_s7 * (B7_SCALE >> oss_q);
			b4_s8 <= b4_s7;
			temp_s8 <= temp_s7;
			err_s8 <= err_s7;
		end
	end

	// pressure divider: b7 below 2^31 is doubled before dividing, else after
	logic [31:0] pnum;
	pside_t pside_in, pside_out;
	logic pdv_vld;
	logic [31:0] pquo;

	always_comb begin
		pside_in.split = !b7_s8[31];
		pnum = b7_s8[31] ? b7_s8 : (b7_s8 << 1);
		pside_in.temp = temp_s8;
		pside_in.bz = (b4_s8 == 32'd0);
		pside_in.err = err_s8 || (b4_s8 == 32'd0);
	end

	bpc_div #(
		.W(DATA_W),
		.SIDE_W($bits(pside_t))
	) u_pdiv (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_vld(vld_s8),
		.num(pnum),
		.den(b4_s8),
		.side(pside_in),
		.out_vld(pdv_vld),
		.quo(pquo),
		.side_out(pside_out)
	);

	// stage 9: resolve p
	logic vld_s9;
	logic [31:0] p_s9;
	logic [15:0] temp_s9;
	logic err_s9;
	logic [31:0] p_t;

	// only a zero b4 forces p to zero, a temperature side error does not
	always_comb begin
		if (pside_out.bz) begin
			p_t = '0;
		end else begin
			p_t = pside_out.split ? pquo : (pquo << 1);
		end
	end

	// stage 10: p squared and linear term
	logic vld_s10;
	logic [31:0] sq_s10, lin_s10, p_s10;
	logic [15:0] temp_s10;
	logic err_s10;
	logic signed [31:0] pa, lin_prod;

	always_comb begin
		pa = signed'(p_s9) >>> 8;
		lin_prod = signed'((32'd0 - P_LIN_COEF) * p_s9);
	end

	// stage 11: square term
	logic vld_s11;
	logic [31:0] x1_s11, x2_s11, p_s11;
	logic [15:0] temp_s11;
	logic err_s11;
	logic signed [31:0] sq_prod;

	always_comb sq_prod = signed'(sq_s10 * P_SQ_COEF);

	// stage 12: output register
	out_t out_q;
	logic out_vld_q;
	logic signed [31:0] corr;

	always_comb corr = signed'(x1_s11 + x2_s11 + P_OFFSET) >>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s9 <= pdv_vld;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			out_vld_q <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9 <= p_t;
			temp_s9 <= pside_out.temp;
			err_s9 <= pside_out.err;

			sq_s10 <= pa * pa;
			lin_s10 <= lin_prod >>> 16;
			p_s10 <= p_s9;
			temp_s10 <= temp_s9;
			err_s10 <= err_s9;

			x1_s11 <= sq_prod >>> 16;
			x2_s11 <= lin_s10;
			p_s11 <= p_s10;
			temp_s11 <= temp_s10;
			err_s11 <= err_s10;

			out_q.temp_decicelsius <= signed'(temp_s11);
			out_q.press_pascal <= signed'(p_s11 + corr);
			out_q.div_error <= err_s11;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import bpc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	baro_pressure_temp_compensation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	localparam int LATENCY = 76;
	localparam int WATCHDOG_LIMIT = 20000;

	// local copy of the calibration registers
	logic [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
	logic [1:0] cal_oss;

	out_t comp_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit out_stall_on = 1;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] asr(logic [31:0] v, int n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	// signed divide truncating toward zero, zero divisor flagged
	function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b, ref bit err);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		if (b == 0) begin
			err = 1;
			return 0;
		end
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// compensation formula, all intermediates wrapped at 32 bits
	function automatic out_t compensate(in_t it);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
		logic [31:0] x1, x2, x3, b3, b4, b5, b6, b6sq, b7, p, press;
		bit err;
		out_t r;
		err = 0;
		ac1 = sx16(cal_ac12[31:16]);
		ac2 = sx16(cal_ac12[15:0]);
		ac3 = sx16(cal_ac34[31:16]);
		ac4 = {16'd0, cal_ac34[15:0]};
		ac5 = {16'd0, cal_ac56[31:16]};
		ac6 = {16'd0, cal_ac56[15:0]};
		b1 = sx16(cal_b12[31:16]);
		b2 = sx16(cal_b12[15:0]);
		mc = sx16(cal_mcmd[31:16]);
		md = sx16(cal_mcmd[15:0]);
		ut = {16'd0, it.raw_temp};
		up = {8'd0, it.raw_press} >> (8 - cal_oss);
		x1 = asr((ut - ac6) * ac5, 15);
		x2 = div_trunc(mc << 11, x1 + md, err);
		b5 = x1 + x2;
		r.temp_decicelsius = 16'(asr(b5 + 8, 4));
		b6 = b5 - TEMP_OFFSET;
		b6sq = asr(b6 * b6, 12);
		x1 = asr(b2 * b6sq, 11);
		x2 = asr(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = asr(((ac1 * 4 + x3) << cal_oss) + 2, 2);
		x1 = asr(ac3 * b6, 13);
		x2 = asr(b1 * b6sq, 16);
		x3 = asr(x1 + x2 + 2, 2);
		b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
		b7 = (up - b3) * (B7_SCALE >> cal_oss);
		if (b4 == 0) begin
			err = 1;
			p = 0;
		end else if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
		else p = (b7 / b4) << 1;
		x1 = asr(p, 8);
		x1 = x1 * x1;
		x1 = asr(x1 * P_SQ_COEF, 16);
		x2 = asr((0 - P_LIN_COEF) * p, 16);
		press = p + asr(x1 + x2 + P_OFFSET, 4);
		r.press_pascal = press;
		r.div_error = err;
		return r;
	endfunction

	// short gaps mostly, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 3);
	endfunction

	// valid stays high between back-to-back writes, load_calib drops it
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_AC1_AC2: cal_ac12 = val;
			REG_AC3_AC4: cal_ac34 = val;
			REG_AC5_AC6: cal_ac56 = val;
			REG_B1_B2: cal_b12 = val;
			REG_MC_MD: cal_mcmd = val;
			REG_OSS: cal_oss = val[1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_calib(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d, logic [31:0] e, logic [1:0] o);
		write_reg(REG_AC1_AC2, a);
		write_reg(REG_AC3_AC4, b);
		write_reg(REG_AC5_AC6, c);
		write_reg(REG_B1_B2, d);
		write_reg(REG_MC_MD, e);
		write_reg(REG_OSS, {30'd0, o});
		cfg_valid <= 0;
	endtask

	// wait for the pipe to drain before touching the registers
	task automatic drain();
		in_valid <= 0;
		while (comp_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// one item, optional typed-in expectation; valid is dropped only for a gap
	task automatic send_item(in_t it, bit has_exp, out_t exp_r);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		comp_q.push_back(has_exp ? exp_r : compensate(it));
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (comp_q.size() == 0) begin
				$display("%0t: unexpected item, actual %h", $time, out_data);
				errors++;
			end else begin
				out_t e;
				e = comp_q.pop_front();
				if (e.temp_decicelsius !== out_data.temp_decicelsius) begin
					$display("%0t: temp expected %0d actual %0d", $time,
						e.temp_decicelsius, out_data.temp_decicelsius);
					errors++;
				end
				if (e.press_pascal !== out_data.press_pascal) begin
					$display("%0t: press expected %0d actual %0d", $time,
						e.press_pascal, out_data.press_pascal);
					errors++;
				end
				if (e.div_error !== out_data.div_error) begin
					$display("%0t: div_error expected %0b actual %0b", $time,
						e.div_error, out_data.div_error);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern
	initial begin
		int g;
		out_ready = 0;
		forever begin
			@(negedge clk);
			g = (out_stall_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
			if (g == 0) out_ready <= 1;
			else begin
				out_ready <= 0;
				repeat (g) @(negedge clk);
				out_ready <= 1;
			end
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| (comp_q.size() == 0 && !in_valid))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	typedef struct {
		logic [15:0] ut;
		logic [23:0] up;
		bit has_exp;
		out_t exp_r;
	} row_t;

	row_t rows[$];

	initial begin
		in_t it;
		out_t zr;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		cal_ac12 = 0; cal_ac34 = 0; cal_ac56 = 0; cal_b12 = 0; cal_mcmd = 0; cal_oss = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// after reset every coefficient is zero: both divisors are zero
		// temp: (0+8)>>4 = 0, p=0 so press = (3791)>>4 = 236
		zr.temp_decicelsius = 0;
		zr.press_pascal = 236;
		zr.div_error = 1;
		rows.push_back('{16'h0000, 24'h000000, 1, zr});
		rows.push_back('{16'hffff, 24'hffffff, 1, zr});
		rows.push_back('{16'h5555, 24'haaaaaa, 1, zr});
		foreach (rows[i]) begin
			it.raw_temp = rows[i].ut;
			it.raw_press = rows[i].up;
			send_item(it, rows[i].has_exp, rows[i].exp_r);
		end
		drain();

		// datasheet-style coefficients, every oversampling setting
		for (int o = 0; o < 4; o++) begin
			load_calib({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
				{16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, o[1:0]);
			it.raw_temp = 16'd27898; it.raw_press = 24'd23843 << (8 - o);
			send_item(it, 0, zr);
			it.raw_temp = 16'h0000; it.raw_press = 24'h000000;
			send_item(it, 0, zr);
			it.raw_temp = 16'hffff; it.raw_press = 24'hffffff;
			send_item(it, 0, zr);
			drain();
		end

		// temperature divisor zero only: ut = ac6 makes x1 zero and md is zero
		load_calib({16'd408, 16'd0}, {16'd0, 16'd32741}, {16'd100, 16'd500},
			32'd0, {16'd5, 16'd0}, 2'd1);
		it.raw_temp = 16'd500; it.raw_press = 24'h123456;
		send_item(it, 0, zr);
		drain();

		// extremes of all coefficients
		load_calib(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 2'd3);
		for (int k = 0; k < 4; k++) begin
			it.raw_temp = (k & 1) ? 16'hffff : 16'h0000;
			it.raw_press = (k & 2) ? 24'hffffff : 24'h000000;
			send_item(it, 0, zr);
		end
		drain();
		load_calib(32'h80008000, 32'h80000000, 32'h00000000, 32'h80008000, 32'h80008000, 2'd0);
		it.raw_temp = 16'h8000; it.raw_press = 24'h800000;
		send_item(it, 0, zr);
		drain();

		// random phases; pause until drained between them
		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 3 == 0)
				load_calib($urandom, $urandom, $urandom, $urandom, $urandom,
					2'($urandom_range(0, 3)));
			else
				load_calib({16'($urandom_range(100, 9000)), 16'(-$signed(16'($urandom_range(0, 1200))))},
					{16'(-$signed(16'($urandom_range(0, 20000)))), 16'($urandom_range(20000, 40000))},
					{16'($urandom_range(20000, 40000)), 16'($urandom_range(10000, 30000))},
					{16'($urandom_range(0, 9000)), 16'($urandom_range(0, 200))},
					{16'(-$signed(16'($urandom_range(1, 12000)))), 16'($urandom_range(1, 5000))},
					2'($urandom_range(0, 3)));
			out_stall_on = (ph != 5);
			for (int n = 0; n < 120; n++) begin
				it.raw_temp = 16'($urandom);
				it.raw_press = 24'($urandom);
				send_item(it, 0, zr);
			end
			drain();
		end

		drain();
		if (errors == 0 && comp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (comp_q.size() != 0)
				$display("%0t: %0d items never arrived", $time, comp_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// File: sim.f
src/bpc_pkg.sv
src/bpc_div.sv
src/baro_pressure_temp_compensation_unit.sv
tb/tb.sv
